FILE: rtl/ksa_pkg.sv
// ----------------------------------------------------------------------------
// Keyed sum accumulator package
// Shared sizes and the packed table entry type of the key/sum table.
// ----------------------------------------------------------------------------
package ksa_pkg;

	// Table geometry and sum width.
	localparam int TABLE_ENTRIES = 256;
	localparam int SUM_BITS      = 16;

	// Fixed item field widths.
	localparam int KEY_W   = 16;
	localparam int VAL_W   = 8;
	localparam int SLOT_W  = 8;
	localparam int TOTAL_W = 16;

	// Derived widths: slot address and a fill count that can hold the depth itself.
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ENT_W = KEY_W + SUM_BITS;

	// One table entry holds a key and its running sum.
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [SUM_BITS-1:0] sum;
	} ksa_entry_t;

endpackage

FILE: rtl/ksa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ksa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/ksa_alu.sv
// ----------------------------------------------------------------------------
// Keyed sum accumulator compare and add unit
// Key equality compare and a saturating add of an item value to a sum.
// ----------------------------------------------------------------------------
module ksa_alu (
	input  logic [ksa_pkg::KEY_W-1:0]    key_a,
	input  logic [ksa_pkg::KEY_W-1:0]    key_b,
	input  logic [ksa_pkg::SUM_BITS-1:0] sum_in,
	input  logic [ksa_pkg::VAL_W-1:0]    add_in,
	output logic                         key_eq,
	output logic [ksa_pkg::SUM_BITS-1:0] sum_out
);

	import ksa_pkg::*;

	logic [SUM_BITS:0] sum_wide;

	// Key compare for the table search.
	assign key_eq = (key_a == key_b);

	// Add with one carry bit; a carry out clamps the sum to all ones.
	assign sum_wide = {1'b0, sum_in} + (SUM_BITS+1)'(add_in);
	assign sum_out  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

endmodule

FILE: rtl/keyed_sum_accumulator.sv
// ----------------------------------------------------------------------------
// Keyed sum accumulator
// Per-key running sums in a table that is searched one entry per cycle.
// ----------------------------------------------------------------------------
// Search: a key found in slot i raises its result strobe once the scan has read
// slot i; a new or dropped key raises it after every used slot has been read.
// Flow: one item at a time; busy falls with the strobe, and the block does not
// accept the next item before it is through with the last one.
// The linear scan over the table RAM read port sets the item time, and the
// receiver cannot stall the strobe. Reset clears the fill count and control
// state; the table contents stay undefined and are only read below the fill count.
// ----------------------------------------------------------------------------
module keyed_sum_accumulator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ksa_pkg::KEY_W-1:0]   student_key,
	input  logic [ksa_pkg::VAL_W-1:0]   add_value,
	output logic                        done,
	output logic [ksa_pkg::SLOT_W-1:0]  slot_index,
	output logic [ksa_pkg::TOTAL_W-1:0] running_total,
	output logic                        inserted,
	output logic                        dropped
);

	import ksa_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t              state_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    used_count_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic                done_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                ins_q;
	logic                drop_q;

	logic                rd_en;
	logic [ENT_W-1:0]    rd_word;
	ksa_entry_t          rd_ent;
	ksa_entry_t          wr_ent;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic                key_eq;
	logic [SUM_BITS-1:0] alu_sum_in;
	logic [SUM_BITS-1:0] alu_sum;
	logic                hit;
	logic                miss;
	logic                full;

	// Scan control: read while entries remain, decide on a match or an empty pipe.
	assign rd_en  = (state_q == ST_SCAN) && (scan_idx_q < used_count_q);
	assign rd_ent = rd_word;
	assign hit    = (state_q == ST_SCAN) && pend_q && key_eq;
	assign miss   = (state_q == ST_SCAN) && !pend_q && (scan_idx_q == used_count_q);
	assign full   = (used_count_q == CNT_W'(TABLE_ENTRIES));

	// A hit adds to the stored sum; a new key starts from zero.
	assign alu_sum_in = pend_q ? rd_ent.sum : '0;

	ksa_alu u_alu (
		.key_a   (key_q),
		.key_b   (rd_ent.key),
		.sum_in  (alu_sum_in),
		.add_in  (val_q),
		.key_eq  (key_eq),
		.sum_out (alu_sum)
	);

	// Write back the updated entry or claim the next free slot.
	assign wr_en      = hit || (miss && !full);
	assign wr_addr    = hit ? pend_idx_q : used_count_q[IDX_W-1:0];
	assign wr_ent.key = key_q;
	assign wr_ent.sum = alu_sum;

	ksa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_word)
	);

	// Sequencer state, search pointers and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_q        <= '0;
			val_q        <= '0;
			used_count_q <= '0;
			scan_idx_q   <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			done_q       <= 1'b0;
			slot_q       <= '0;
			total_q      <= '0;
			ins_q        <= 1'b0;
			drop_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q      <= student_key;
						val_q      <= add_value;
						scan_idx_q <= '0;
						pend_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q     <= rd_en;
					pend_idx_q <= scan_idx_q[IDX_W-1:0];
					if (rd_en) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (hit) begin
						slot_q  <= SLOT_W'(pend_idx_q);
						total_q <= TOTAL_W'(alu_sum);
						ins_q   <= 1'b0;
						drop_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (miss) begin
						if (full) begin
							slot_q  <= '0;
							total_q <= '0;
							ins_q   <= 1'b0;
							drop_q  <= 1'b1;
						end else begin
							slot_q       <= SLOT_W'(used_count_q[IDX_W-1:0]);
							total_q      <= TOTAL_W'(alu_sum);
							ins_q        <= 1'b1;
							drop_q       <= 1'b0;
							used_count_q <= used_count_q + CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign slot_index    = slot_q;
	assign running_total = total_q;
	assign inserted      = ins_q;
	assign dropped       = drop_q;

	// The result strobe comes only once the search has finished.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while a search is running");

	// A result is never both a new entry and a drop.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !(inserted && dropped))
		else $error("inserted and dropped flagged together");

	// A dropped item reports slot zero and a zero total.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (slot_index == '0 && running_total == '0))
		else $error("dropped item with nonzero slot or total");

	// The fill count never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table depth");

	// An accepted item starts a search on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted item did not start a search");

endmodule
